>>> sv/wlru_pkg.sv
// ---------------------------------------------------------------------------
// wlru_pkg
// Shared types, field widths and defaults for the weighted LRU victim selector.
// ---------------------------------------------------------------------------
package wlru_pkg;

  // Default geometry
  localparam int SETS_DEF        = 64;
  localparam int WAYS_DEF        = 8;
  localparam int WEIGHT_BITS_DEF = 16;

  // Fixed channel field widths
  localparam int SET_W  = 6;
  localparam int WAY_W  = 3;
  localparam int OCC_W  = 16;
  localparam int TIME_W = 32;
  localparam int VWAY_W = 3;

  // Request opcodes
  typedef enum logic [0:0] {
    OP_TOUCH  = 1'b0,
    OP_VICTIM = 1'b1
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_REDUCE,
    ST_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_wr;      // write zeros to the row under the clear counter
    logic acc_touch;   // touch transfer this cycle
    logic acc_victim;  // victim transfer this cycle, row read issued
    logic load_row;    // load comparator array from the read row
    logic reduce;      // one comparator level
    logic load_out;    // load the result register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;    // clear counter is on the last row
  } ctrl_stat_t;

endpackage

>>> sv/wlru_if.sv
// ---------------------------------------------------------------------------
// wlru_in_if / wlru_out_if
// Valid/ready channels for requests and victim results.
// ---------------------------------------------------------------------------
interface wlru_in_if import wlru_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [SET_W-1:0]  set_index;
  logic [WAY_W-1:0]  way;
  logic [OCC_W-1:0]  occupancy;
  logic [TIME_W-1:0] time_stamp;

  modport source (output valid, operation, set_index, way, occupancy, time_stamp,
                  input ready);
  modport sink   (input valid, operation, set_index, way, occupancy, time_stamp,
                  output ready);
endinterface

interface wlru_out_if import wlru_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VWAY_W-1:0] victim_way;

  modport source (output valid, victim_way, input ready);
  modport sink   (input valid, victim_way, output ready);
endinterface

>>> sv/wlru_ram.sv
// ---------------------------------------------------------------------------
// wlru_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module wlru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/wlru_dp.sv
// ---------------------------------------------------------------------------
// wlru_dp
// Datapath: per-way weight/time RAMs, clear counter, iterated comparator
// array and result register.
// ---------------------------------------------------------------------------
module wlru_dp import wlru_pkg::*; #(
  parameter int SETS        = SETS_DEF,
  parameter int WAYS        = WAYS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         cmd,
  output ctrl_stat_t        stat,
  input  logic [SET_W-1:0]  set_index,
  input  logic [WAY_W-1:0]  way,
  input  logic [OCC_W-1:0]  occupancy,
  input  logic [TIME_W-1:0] time_stamp,
  output logic [VWAY_W-1:0] victim_way
);

  localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int LVLS   = $clog2(WAYS);
  localparam int PW     = 1 << LVLS;
  localparam int KEY_W  = WEIGHT_BITS + TIME_W;

  logic [31:0]       set_ext;
  logic [31:0]       occ_ext;
  logic [31:0]       idx_ext;
  logic [SET_AW-1:0] set_addr;
  logic              set_ok;
  logic              way_ok;
  logic [SET_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [SET_AW-1:0] wr_addr;
  logic [KEY_W-1:0]  wr_data;
  logic [KEY_W-1:0]  rd_data [WAYS];
  logic [WAYS-1:0]   way_we;
  logic              set_oor_r, set_oor_nxt;
  logic [KEY_W-1:0]  key_r [PW];
  logic [KEY_W-1:0]  key_nxt [PW];
  logic [LVLS-1:0]   idx_r [PW];
  logic [LVLS-1:0]   idx_nxt [PW];
  logic [VWAY_W-1:0] victim_r, victim_nxt;

  // Request decode
  assign set_ext  = 32'(set_index);
  assign occ_ext  = 32'(occupancy);
  assign set_addr = set_ext[SET_AW-1:0];
  assign set_ok   = set_ext < 32'(SETS);
  assign way_ok   = 32'(way) < 32'(WAYS);

  // Write port: clear sweep or touch; key is weight over time
  assign wr_addr = cmd.clr_wr ? clr_cnt_r : set_addr;
  assign wr_data = cmd.clr_wr ? '0 : {occ_ext[WEIGHT_BITS-1:0], time_stamp};

  // One RAM per way, all read at the same set
  for (genvar g = 0; g < WAYS; g++) begin : g_way
    assign way_we[g] = cmd.clr_wr ||
                       (cmd.acc_touch && set_ok && way_ok && (32'(way) == g));
    wlru_ram #(
      .WIDTH(KEY_W),
      .DEPTH(SETS)
    ) u_ram (
      .clk  (clk),
      .we   (way_we[g]),
      .waddr(wr_addr),
      .wdata(wr_data),
      .re   (cmd.acc_victim),
      .raddr(set_addr),
      .rdata(rd_data[g])
    );
  end

  // Clear sweep counter
  assign clr_cnt_nxt   = cmd.clr_wr ? clr_cnt_r + 1'b1 : clr_cnt_r;
  assign stat.clr_last = clr_cnt_r == SET_AW'(SETS - 1);

  // Out-of-range set flag for the pending victim request
  assign set_oor_nxt = cmd.acc_victim ? !set_ok : set_oor_r;

  // Comparator array: load, then halve in place once per step.
  // Padding entries hold the largest key and a higher index, so never win.
  always_comb begin
    for (int n = 0; n < PW; n++) begin
      key_nxt[n] = key_r[n];
      idx_nxt[n] = idx_r[n];
    end
    if (cmd.load_row) begin
      for (int n = 0; n < WAYS; n++) begin
        key_nxt[n] = rd_data[n];
        idx_nxt[n] = LVLS'(n);
      end
      for (int n = WAYS; n < PW; n++) begin
        key_nxt[n] = '1;
        idx_nxt[n] = LVLS'(n);
      end
    end else if (cmd.reduce) begin
      for (int n = 0; n < PW / 2; n++) begin
        // strict less: ties keep the lower way
        if (key_r[2*n+1] < key_r[2*n]) begin
          key_nxt[n] = key_r[2*n+1];
          idx_nxt[n] = idx_r[2*n+1];
        end else begin
          key_nxt[n] = key_r[2*n];
          idx_nxt[n] = idx_r[2*n];
        end
      end
    end
  end

  // Result register
  assign idx_ext    = 32'(idx_r[0]);
  assign victim_nxt = cmd.load_out ? (set_oor_r ? '0 : idx_ext[VWAY_W-1:0]) : victim_r;
  assign victim_way = victim_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    set_oor_r <= set_oor_nxt;
    victim_r  <= victim_nxt;
    key_r     <= key_nxt;
    idx_r     <= idx_nxt;
  end

endmodule

>>> sv/wlru_ctrl.sv
// ---------------------------------------------------------------------------
// wlru_ctrl
// Controller: clear sweep, request acceptance, reduction sequencing and
// result valid.
// ---------------------------------------------------------------------------
module wlru_ctrl import wlru_pkg::*; #(
  parameter int WAYS = WAYS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  op_t        in_op,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  localparam int LVLS   = $clog2(WAYS);
  localparam int STEP_W = $clog2(LVLS + 1);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;
  logic              last_step;

  assign out_free  = !out_valid_r || out_ready;
  assign last_step = step_r == STEP_W'(LVLS - 1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (stat.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid && in_op == OP_VICTIM) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_REDUCE;
      ST_REDUCE: if (last_step) state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.acc_touch  = in_valid && in_op == OP_TOUCH;
        cmd.acc_victim = in_valid && in_op == OP_VICTIM;
      end
      ST_READ: begin
        cmd.load_row = 1'b1;
      end
      ST_REDUCE: begin
        cmd.reduce = 1'b1;
      end
      ST_OUT: begin
        cmd.load_out = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Step counter and result valid
  assign step_nxt      = (state_r == ST_REDUCE) ? step_r + 1'b1 : '0;
  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // A result is never loaded over one that has not been transferred
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");

  // A victim request always starts the row read sequence
  a_victim_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == OP_VICTIM) |=> state_r == ST_READ)
    else $error("victim request did not start a row read");

  // Result valid only rises out of the output state
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result valid raised outside output state");

  // Reduction never runs past the last comparator level
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REDUCE) |-> (step_r <= STEP_W'(LVLS - 1)))
    else $error("reduction step counter overran");
`endif

endmodule

>>> sv/weighted_lru_victim_select.sv
// Timing: a touch is written in the cycle it is transferred; a victim request passes
// the registered row read, the comparator load, one comparator level per cycle and
// the result register. No request is taken after a victim until its result is loaded.
// One touch per cycle while idle; touches proceed while a loaded result waits.
// Reset: synchronous, active low; then a clear sweep zeroes the store, one row
// per cycle, with in_chan.ready low.
// ---------------------------------------------------------------------------
// weighted_lru_victim_select
// Weighted LRU replacement: records per-way weight and touch time, returns the
// way with least weight, oldest touch on ties, lowest way on full ties.
// ---------------------------------------------------------------------------
module weighted_lru_victim_select import wlru_pkg::*; #(
  parameter int SETS        = SETS_DEF,
  parameter int WAYS        = WAYS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  wlru_in_if.sink     in_chan,
  wlru_out_if.source  out_chan
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  wlru_ctrl #(
    .WAYS(WAYS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_op    (op_t'(in_chan.operation)),
    .in_ready (in_chan.ready),
    .out_valid(out_chan.valid),
    .out_ready(out_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wlru_dp #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .set_index (in_chan.set_index),
    .way       (in_chan.way),
    .occupancy (in_chan.occupancy),
    .time_stamp(in_chan.time_stamp),
    .victim_way(out_chan.victim_way)
  );

endmodule

>>> tb/tb_weighted_lru_victim_select.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_weighted_lru_victim_select
// Self-checking bench for the weighted LRU victim selector. A queue of touch
// and victim requests is driven in random bursts. A shadow copy of the weight
// and touch-time store predicts each victim way, and every result transfer is
// compared with the oldest prediction. The result side stalls on its own
// changing pattern.
// ---------------------------------------------------------------------------
module tb_weighted_lru_victim_select;
  import wlru_pkg::*;

  localparam int RANDOM_REQS = 1800;

  typedef struct {
    op_t               op;
    logic [SET_W-1:0]  set_idx;
    logic [WAY_W-1:0]  way;
    logic [OCC_W-1:0]  occ;
    logic [TIME_W-1:0] stamp;
  } request_t;

  // Result-side stall patterns
  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_PERIODIC,
    RDY_BURSTY
  } rdy_mode_t;

  logic clk;
  logic rst_n;

  wlru_in_if  in_bus ();
  wlru_out_if out_bus ();

  weighted_lru_victim_select DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // Pending requests and predicted victim ways
  request_t          req_q[$];
  logic [VWAY_W-1:0] victim_expect_q[$];

  // Shadow of the replacement state
  logic [WEIGHT_BITS_DEF-1:0] wt_mem [SETS_DEF][WAYS_DEF];
  logic [TIME_W-1:0]          ts_mem [SETS_DEF][WAYS_DEF];

  logic [TIME_W-1:0] clock_now;
  int err_count;
  int n_touch;
  int n_victim;
  int n_checked;
  int way_hits [WAYS_DEF];
  bit req_taken;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Least weight, then oldest touch, then lowest way
  function automatic logic [VWAY_W-1:0] lightest_way(input int unsigned s);
    int unsigned best;
    best = 0;
    for (int w = 1; w < WAYS_DEF; w++) begin
      if (wt_mem[s][w] < wt_mem[s][best] ||
          (wt_mem[s][w] == wt_mem[s][best] && ts_mem[s][w] < ts_mem[s][best])) begin
        best = w;
      end
    end
    return best[VWAY_W-1:0];
  endfunction

  // Update the shadow store or queue the predicted victim
  task automatic apply_request(input request_t r);
    if (r.op == OP_TOUCH) begin
      n_touch++;
      if (r.set_idx < SETS_DEF && r.way < WAYS_DEF) begin
        wt_mem[r.set_idx][r.way] = r.occ[WEIGHT_BITS_DEF-1:0];
        ts_mem[r.set_idx][r.way] = r.stamp;
      end
    end else begin
      n_victim++;
      if (r.set_idx < SETS_DEF) begin
        victim_expect_q.push_back(lightest_way(r.set_idx));
      end else begin
        victim_expect_q.push_back('0);
      end
    end
  endtask

  task automatic add_touch(input int unsigned s, input int unsigned w,
                           input int unsigned occ, input logic [TIME_W-1:0] stamp);
    request_t r;
    r.op      = OP_TOUCH;
    r.set_idx = SET_W'(s);
    r.way     = WAY_W'(w);
    r.occ     = OCC_W'(occ);
    r.stamp   = stamp;
    req_q.push_back(r);
  endtask

  // Way and payload carry noise; the block ignores them on a lookup
  task automatic add_victim(input int unsigned s);
    request_t r;
    r.op      = OP_VICTIM;
    r.set_idx = SET_W'(s);
    r.way     = WAY_W'($urandom_range(0, 7));
    r.occ     = OCC_W'($urandom);
    r.stamp   = $urandom;
    req_q.push_back(r);
  endtask

  // Weights cluster at both ends so ties are common
  function automatic logic [OCC_W-1:0] pick_weight();
    case ($urandom_range(0, 3))
      0, 1:    return OCC_W'($urandom_range(0, 3));
      2:       return 16'hFFFF - OCC_W'($urandom_range(0, 3));
      default: return OCC_W'($urandom);
    endcase
  endfunction

  // Mostly a slowly advancing clock that wraps; equal stamps now and then
  function automatic logic [TIME_W-1:0] pick_stamp();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom;
    end
    clock_now = clock_now + $urandom_range(0, 3);
    return clock_now;
  endfunction

  // Input monitor: feed the predictor on each request transfer
  always @(posedge clk) begin : req_mon
    request_t seen;
    req_taken = 1'b0;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      req_taken     = 1'b1;
      seen.op       = op_t'(in_bus.operation);
      seen.set_idx  = in_bus.set_index;
      seen.way      = in_bus.way;
      seen.occ      = in_bus.occupancy;
      seen.stamp    = in_bus.time_stamp;
      apply_request(seen);
    end
  end

  // Request driver: bursts of random length separated by random gaps
  int burst_left;
  int gap_left;

  always @(negedge clk) begin : req_drv
    request_t nxt;
    logic     drive_valid;
    drive_valid = in_bus.valid;
    if (rst_n && !(in_bus.valid && !req_taken)) begin
      drive_valid = 1'b0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (req_q.size() > 0) begin
        nxt = req_q.pop_front();
        in_bus.operation  <= nxt.op;
        in_bus.set_index  <= nxt.set_idx;
        in_bus.way        <= nxt.way;
        in_bus.occupancy  <= nxt.occ;
        in_bus.time_stamp <= nxt.stamp;
        drive_valid = 1'b1;
        burst_left--;
      end
    end
    in_bus.valid <= drive_valid;
  end

  // Result ready: a stall pattern picked at random, changed when its run ends
  rdy_mode_t stall_mode;
  int        mode_left;
  int        stall_left;

  always @(negedge clk) begin : res_rdy
    logic rdy;
    if (mode_left == 0) begin
      stall_mode = rdy_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(50, 300);
    end
    mode_left--;
    case (stall_mode)
      RDY_ALWAYS:   rdy = 1'b1;
      RDY_COIN:     rdy = 1'($urandom_range(0, 1));
      RDY_PERIODIC: rdy = (mode_left % 3 == 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
        end
      end
    endcase
    out_bus.ready <= rdy;
  end

  // Result monitor: compare each transfer with the oldest prediction
  always @(posedge clk) begin : res_mon
    logic [VWAY_W-1:0] exp_way;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (victim_expect_q.size() == 0) begin
        err_count++;
        $display("%0t ERROR: victim result with none pending: expected none, actual way %0d",
                 $time, out_bus.victim_way);
      end else begin
        exp_way = victim_expect_q.pop_front();
        n_checked++;
        way_hits[exp_way]++;
        if (out_bus.victim_way !== exp_way) begin
          err_count++;
          $display("%0t ERROR: victim_way mismatch: expected %0d, actual %0d",
                   $time, exp_way, out_bus.victim_way);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #1ms;
    $display("%0t ERROR: timeout with %0d requests and %0d results outstanding",
             $time, req_q.size(), victim_expect_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus, reset and end of run
  initial begin : main
    int unsigned s;
    int unsigned n;
    int          n_dir;
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.operation   = OP_TOUCH;
    in_bus.set_index   = '0;
    in_bus.way         = '0;
    in_bus.occupancy   = '0;
    in_bus.time_stamp  = '0;
    out_bus.ready      = 1'b0;
    req_taken          = 1'b0;
    burst_left         = 0;
    gap_left           = 0;
    mode_left          = 0;
    stall_left         = 0;
    stall_mode         = RDY_ALWAYS;
    err_count          = 0;
    n_touch            = 0;
    n_victim           = 0;
    n_checked          = 0;
    clock_now          = 32'hFFFF_FC00;
    foreach (way_hits[i]) way_hits[i] = 0;
    foreach (wt_mem[i, j]) begin
      wt_mem[i][j] = '0;
      ts_mem[i][j] = '0;
    end

    // Fresh store: all ways tie at zero, lowest way wins
    add_victim(0);
    // Extreme fields; untouched ways still win
    add_touch(63, 7, 16'hFFFF, 32'hFFFF_FFFF);
    add_victim(63);
    // Equal weights, oldest stamp wins
    for (int w = 0; w < 8; w++) add_touch(10, w, 100, 1000 - w * 10);
    add_victim(10);
    // Largest stamp makes a way newest
    add_touch(10, 7, 100, 32'hFFFF_FFFF);
    add_victim(10);
    // Wrapped stamp counts as oldest
    add_touch(10, 2, 100, 32'h0);
    add_victim(10);
    // Lower weight beats a newer stamp
    add_touch(10, 4, 99, 32'hFFFF_FFFF);
    add_victim(10);
    // Full tie among never-touched ways
    add_touch(20, 0, 1, 32'h0);
    add_victim(20);
    n_dir = req_q.size();

    // Random: mostly fill-then-lookup on a hot set, plus stray touches and lookups
    while (req_q.size() < n_dir + RANDOM_REQS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          s = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 63);
          n = $urandom_range(1, 8);
          repeat (n) add_touch(s, $urandom_range(0, 7), pick_weight(), pick_stamp());
          add_victim(s);
        end
        6, 7:    add_touch($urandom_range(0, 63), $urandom_range(0, 7), $urandom, $urandom);
        default: add_victim($urandom_range(0, 63));
      endcase
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_bus.valid) @(posedge clk);
    while (victim_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d touches and %0d victim lookups; %0d results checked.",
             n_touch, n_victim, n_checked);
    $display("Victims by way: %0d %0d %0d %0d %0d %0d %0d %0d", way_hits[0], way_hits[1],
             way_hits[2], way_hits[3], way_hits[4], way_hits[5], way_hits[6], way_hits[7]);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/wlru_pkg.sv
sv/wlru_if.sv
sv/wlru_ram.sv
sv/wlru_dp.sv
sv/wlru_ctrl.sv
sv/weighted_lru_victim_select.sv
tb/tb_weighted_lru_victim_select.sv
